### src/mlfh_pkg.sv
`timescale 1ns / 1ps

package mlfh_pkg;

  localparam int WAIT_DEPTH = 16;
  localparam int PTR_W      = $clog2(WAIT_DEPTH);
  localparam int CNT_W      = $clog2(WAIT_DEPTH + 1);
  localparam int TID_W      = 8;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_QUEUED    = 3'd2,
    ST_FREED     = 3'd3,
    ST_HANDOFF   = 3'd4,
    ST_NOT_OWNER = 3'd5,
    ST_FULL      = 3'd6
  } status_e_t;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request and read the head waiter
    logic commit;   // apply the request and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;  // the result register can take a new result now
  } dp_sts_t;

endpackage

### src/mlfh_ram.sv
`timescale 1ns / 1ps

module mlfh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/mlfh_ctrl.sv
`timescale 1ns / 1ps

module mlfh_ctrl
  import mlfh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      CS_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = CS_EXEC;
        end
      end
      CS_EXEC: begin
        // The head entry read on capture in CS_IDLE is valid here.
        if (sts.slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

endmodule

### src/mlfh_dp.sv
`timescale 1ns / 1ps

module mlfh_dp
  import mlfh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts,
  input  logic                  in_op,
  input  logic [TID_W-1:0]      in_tid,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic             busy_r, busy_nxt;
  logic [TID_W-1:0] owner_r, owner_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             op_r;
  logic [TID_W-1:0] tid_r;
  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic             is_owner;
  logic             q_push;
  logic             q_pop;
  logic [TID_W-1:0] head_tid;
  logic [TID_W-1:0] woken;
  logic             woken_vld;
  status_e_t        status;

  mlfh_ram #(
    .WIDTH (TID_W),
    .DEPTH (WAIT_DEPTH)
  ) u_wait_ram (
    .clk     (clk),
    .wr_en   (q_push),
    .wr_addr (tail_r),
    .wr_data (tid_r),
    .rd_en   (cmd.capture),
    .rd_addr (head_r),
    .rd_data (head_tid)
  );

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(WAIT_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + PTR_W'(1);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      tid_r <= in_tid;
    end
  end

  // Decision for the captured request against the current lock state.
  always_comb begin
    is_owner  = busy_r && (owner_r == tid_r);
    busy_nxt  = busy_r;
    owner_nxt = owner_r;
    q_push    = 1'b0;
    q_pop     = 1'b0;
    woken     = '0;
    woken_vld = 1'b0;
    status    = ST_NOT_OWNER;
    if (op_r == OP_ACQUIRE) begin
      priority if (is_owner) begin
        status = ST_ALREADY;
      end else if (!busy_r) begin
        busy_nxt  = 1'b1;
        owner_nxt = tid_r;
        status    = ST_GRANTED;
      end else if (cnt_r >= CNT_W'(WAIT_DEPTH)) begin
        status = ST_FULL;
      end else begin
        q_push = cmd.commit;
        status = ST_QUEUED;
      end
    end else begin
      priority if (!is_owner) begin
        status = ST_NOT_OWNER;
      end else if (cnt_r != '0) begin
        q_pop     = cmd.commit;
        woken     = head_tid;
        woken_vld = 1'b1;
        owner_nxt = head_tid;
        status    = ST_HANDOFF;
      end else begin
        busy_nxt  = 1'b0;
        owner_nxt = '0;
        status    = ST_FREED;
      end
    end
    head_nxt = q_pop ? ptr_inc(head_r) : head_r;
    tail_nxt = q_push ? ptr_inc(tail_r) : tail_r;
    cnt_nxt  = cnt_r + CNT_W'(q_push) - CNT_W'(q_pop);
    out_data_nxt = {2'b00, (cnt_nxt == '0), busy_nxt, owner_nxt,
                    woken_vld, woken, status};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      owner_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
    end else if (cmd.commit) begin
      busy_r  <= busy_nxt;
      owner_r <= owner_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign sts.slot_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WAIT_DEPTH))
    else $error("wait count exceeds queue depth");

  a_free_no_waiters: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cnt_r == '0))
    else $error("threads wait on a free lock");

  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed request produced no result");

  a_handoff_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && q_pop) |=> (busy_r && (owner_r == $past(head_tid))))
    else $error("handoff did not pass the lock to the head waiter");

endmodule

### src/mutex_lock_fifo_handoff_unit.sv
`timescale 1ns / 1ps
// A request is captured in CS_IDLE and committed in CS_EXEC once the result register is free,
// and the commit loads its result on out_*. No new request is accepted before that commit;
// the registered wait-queue RAM read comes first, then the lock update with the result load.
// A result waiting on out_* does not block acceptance of the next request.
// Reset (rst_n low, synchronous): lock free, owner 0, queue empty; queue RAM is not cleared.
module mutex_lock_fifo_handoff_unit
  import mlfh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] thread_id
  input  logic                  in_tuser,   // [0] operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] status, [10:3] woken_thread, [11] woken_valid, [19:12] owner_now,
  // [20] busy_now, [21] queue_empty, [23:22] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  mlfh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlfh_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_tid     (in_tdata[TID_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
